>>> sv/ptzfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptzfe_pkg
// Opcodes, frame byte codes and the speed lookup shared by the PTZ command
// frame encoder.
// ----------------------------------------------------------------------------
package ptzfe_pkg;

    typedef logic [3:0] t_opcode;
    typedef logic [7:0] t_byte;

    // Command opcodes as they arrive on the input channel.
    localparam t_opcode OP_PAN_LEFT    = 4'd0;
    localparam t_opcode OP_PAN_RIGHT   = 4'd1;
    localparam t_opcode OP_TILT_UP     = 4'd2;
    localparam t_opcode OP_TILT_DOWN   = 4'd3;
    localparam t_opcode OP_ZOOM_TELE   = 4'd4;
    localparam t_opcode OP_ZOOM_WIDE   = 4'd5;
    localparam t_opcode OP_IRIS_OPEN   = 4'd6;
    localparam t_opcode OP_IRIS_CLOSE  = 4'd7;
    localparam t_opcode OP_FOCUS_FAR   = 4'd8;
    localparam t_opcode OP_FOCUS_NEAR  = 4'd9;
    localparam t_opcode OP_STOP        = 4'd10;
    localparam t_opcode OP_SET_PRESET  = 4'd11;
    localparam t_opcode OP_GOTO_PRESET = 4'd12;
    localparam t_opcode OP_OTHER       = 4'd13;
    localparam t_opcode OP_NONE        = 4'd14;

    // Command group bytes.
    localparam t_byte CMD_PAN_TILT   = 8'h18;
    localparam t_byte CMD_ZOOM       = 8'h24;
    localparam t_byte CMD_IRIS       = 8'h23;
    localparam t_byte CMD_FOCUS      = 8'h25;
    localparam t_byte CMD_SET_PRESET = 8'h1d;
    localparam t_byte CMD_GOTO       = 8'h11;
    localparam t_byte CMD_PAN_STOP   = 8'h13;
    localparam t_byte CMD_TILT_STOP  = 8'h14;

    // Sub-codes and fixed data bytes.
    localparam t_byte SUB_0          = 8'h00;
    localparam t_byte SUB_1          = 8'h01;
    localparam t_byte SUB_2          = 8'h02;
    localparam t_byte SUB_3          = 8'h03;
    localparam t_byte SUB_FOCUS_STOP = 8'h04;
    localparam t_byte SUB_FOCUS_NEAR = 8'h05;
    localparam t_byte SUB_IRIS_STOP  = 8'h05;
    localparam t_byte SUB_FOCUS_FAR  = 8'h06;
    localparam t_byte DATA_FOCUS     = 8'h0f;

    // Configuration register indexes and reset values.
    localparam logic REG_CAMERA_ADDRESS = 1'b0;
    localparam logic REG_DEFAULT_SPEED  = 1'b1;
    localparam t_byte      RST_CAMERA_ADDRESS = 8'd1;
    localparam logic [6:0] RST_DEFAULT_SPEED  = 7'd50;

    // Speed code for a speed percent: below 30 gives 1, then one step per ten
    // up to 7 for 90 to 99, but 50 to 69 share 4; 100 and up give 8'h10.
    function automatic t_byte speed_code(input logic [7:0] percent);
        t_byte code;
        if (percent < 8'd30) begin
            code = 8'h01;
        end else if (percent < 8'd40) begin
            code = 8'h02;
        end else if (percent < 8'd50) begin
            code = 8'h03;
        end else if (percent < 8'd70) begin
            code = 8'h04;
        end else if (percent < 8'd80) begin
            code = 8'h05;
        end else if (percent < 8'd90) begin
            code = 8'h06;
        end else if (percent < 8'd100) begin
            code = 8'h07;
        end else begin
            code = 8'h10;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

>>> sv/ptz_command_frame_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptz_command_frame_encoder_unit
// Turns one pan/tilt/zoom command into a six-byte camera control frame.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one command item (opcode and argument) per
// accepted handshake: an item is taken at a rising edge where i_in_valid is
// high and o_in_stall is low. Every command yields exactly one frame item on
// the output channel, taken at an edge where o_out_valid is high and
// i_out_stall is low. The frame bytes appear on separate ports; byte 1 is
// always zero and byte 5 is the XOR check over bytes 0 to 4.
// The frame is decoded from the accepted command in the same cycle and sits
// in the output register from the next cycle on. Throughput is one item per
// clock when unstalled, set by the single output register; a new command
// is accepted in the same cycle that the previous frame leaves. When the
// receiver stalls, the frame holds and o_in_stall goes high only while the
// output register is full and stalled. Reset (synchronous, active low)
// empties the output register, restores the camera address to 1 and the
// default speed to 50, and forgets the last motion command so that a stop
// right after reset sends zero command bytes. Configuration is written over
// the APB port by the user only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module ptz_command_frame_encoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Command input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [7:0]  i_argument,
    // Frame output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [7:0]  o_frame_address,
    output logic      [7:0]  o_frame_reserved,
    output logic      [7:0]  o_frame_command,
    output logic      [7:0]  o_frame_subcode,
    output logic      [7:0]  o_frame_data,
    output logic      [7:0]  o_frame_check
);

    // Configuration registers.
    logic [7:0] r_camera_address;
    logic [6:0] r_default_speed;

    // Last command that was not a stop; selects the stop frame.
    ptzfe_pkg::t_opcode r_last_cmd;
    ptzfe_pkg::t_opcode n_last_cmd;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_address;
    logic [7:0] r_command;
    logic [7:0] r_subcode;
    logic [7:0] r_data;
    logic [7:0] r_check;
    logic [7:0] n_command;
    logic [7:0] n_subcode;
    logic [7:0] n_data;

    logic               in_accept;
    logic               out_free;
    logic               cfg_write;
    ptzfe_pkg::t_opcode op;
    logic [7:0]         speed_percent;
    logic [7:0]         speed;

    // The output register can take a new frame when it is empty or when its
    // current frame leaves in this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !out_free;
    assign in_accept  = i_in_valid && out_free;

    // ------------------------------------------------------------------
    // Configuration port. The register index is address bit 2; the low
    // address bits are not decoded.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camera_address <= ptzfe_pkg::RST_CAMERA_ADDRESS;
            r_default_speed  <= ptzfe_pkg::RST_DEFAULT_SPEED;
        end else if (cfg_write) begin
            if (paddr[2] == ptzfe_pkg::REG_CAMERA_ADDRESS) begin
                r_camera_address <= pwdata[7:0];
            end else begin
                r_default_speed <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ptzfe_pkg::REG_CAMERA_ADDRESS) begin
            prdata = {24'd0, r_camera_address};
        end else begin
            prdata = {25'd0, r_default_speed};
        end
    end

    // ------------------------------------------------------------------
    // Command decode. Opcodes above "other" are folded into "other".
    // A zero argument selects the configured default speed.
    // ------------------------------------------------------------------
    assign op = (i_opcode > ptzfe_pkg::OP_OTHER) ? ptzfe_pkg::OP_OTHER : i_opcode;
    assign speed_percent = (i_argument != 8'd0) ? i_argument : {1'b0, r_default_speed};
    assign speed = ptzfe_pkg::speed_code(speed_percent);

    always_comb begin
        n_command = 8'd0;
        n_subcode = 8'd0;
        n_data    = 8'd0;
        case (op)
            ptzfe_pkg::OP_PAN_LEFT: begin
                n_command = ptzfe_pkg::CMD_PAN_TILT;
                n_subcode = ptzfe_pkg::SUB_1;
                n_data    = speed;
            end
            ptzfe_pkg::OP_PAN_RIGHT: begin
                n_command = ptzfe_pkg::CMD_PAN_TILT;
                n_subcode = ptzfe_pkg::SUB_0;
                n_data    = speed;
            end
            ptzfe_pkg::OP_TILT_UP: begin
                n_command = ptzfe_pkg::CMD_PAN_TILT;
                n_subcode = ptzfe_pkg::SUB_2;
                n_data    = speed;
            end
            ptzfe_pkg::OP_TILT_DOWN: begin
                n_command = ptzfe_pkg::CMD_PAN_TILT;
                n_subcode = ptzfe_pkg::SUB_3;
                n_data    = speed;
            end
            ptzfe_pkg::OP_ZOOM_TELE: begin
                n_command = ptzfe_pkg::CMD_ZOOM;
                n_subcode = ptzfe_pkg::SUB_1;
            end
            ptzfe_pkg::OP_ZOOM_WIDE: begin
                n_command = ptzfe_pkg::CMD_ZOOM;
                n_subcode = ptzfe_pkg::SUB_0;
            end
            ptzfe_pkg::OP_IRIS_OPEN: begin
                n_command = ptzfe_pkg::CMD_IRIS;
                n_subcode = ptzfe_pkg::SUB_2;
            end
            ptzfe_pkg::OP_IRIS_CLOSE: begin
                n_command = ptzfe_pkg::CMD_IRIS;
                n_subcode = ptzfe_pkg::SUB_3;
            end
            ptzfe_pkg::OP_FOCUS_FAR: begin
                n_command = ptzfe_pkg::CMD_FOCUS;
                n_subcode = ptzfe_pkg::SUB_FOCUS_FAR;
                n_data    = ptzfe_pkg::DATA_FOCUS;
            end
            ptzfe_pkg::OP_FOCUS_NEAR: begin
                n_command = ptzfe_pkg::CMD_FOCUS;
                n_subcode = ptzfe_pkg::SUB_FOCUS_NEAR;
                n_data    = ptzfe_pkg::DATA_FOCUS;
            end
            ptzfe_pkg::OP_STOP: begin
                // The stop frame belongs to the group of the last motion.
                // Zoom, presets, other and no command have no stop frame.
                case (r_last_cmd)
                    ptzfe_pkg::OP_FOCUS_FAR, ptzfe_pkg::OP_FOCUS_NEAR: begin
                        n_command = ptzfe_pkg::CMD_FOCUS;
                        n_subcode = ptzfe_pkg::SUB_FOCUS_STOP;
                    end
                    ptzfe_pkg::OP_IRIS_OPEN, ptzfe_pkg::OP_IRIS_CLOSE: begin
                        n_command = ptzfe_pkg::CMD_IRIS;
                        n_subcode = ptzfe_pkg::SUB_IRIS_STOP;
                    end
                    ptzfe_pkg::OP_PAN_LEFT, ptzfe_pkg::OP_PAN_RIGHT: begin
                        n_command = ptzfe_pkg::CMD_PAN_STOP;
                    end
                    ptzfe_pkg::OP_TILT_UP, ptzfe_pkg::OP_TILT_DOWN: begin
                        n_command = ptzfe_pkg::CMD_TILT_STOP;
                    end
                    default: begin
                        n_command = 8'd0;
                    end
                endcase
            end
            ptzfe_pkg::OP_SET_PRESET: begin
                n_command = ptzfe_pkg::CMD_SET_PRESET;
                n_data    = i_argument;
            end
            ptzfe_pkg::OP_GOTO_PRESET: begin
                n_command = ptzfe_pkg::CMD_GOTO;
                n_data    = i_argument;
            end
            default: begin
                n_command = 8'd0;
            end
        endcase
    end

    // A stop leaves the remembered command alone; everything else replaces it.
    assign n_last_cmd = (op == ptzfe_pkg::OP_STOP) ? r_last_cmd : op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cmd  <= ptzfe_pkg::OP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_last_cmd <= n_last_cmd;
            end
            if (out_free) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    // Frame payload; the camera address is sampled with the command.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_address <= r_camera_address;
            r_command <= n_command;
            r_subcode <= n_subcode;
            r_data    <= n_data;
            r_check   <= r_camera_address ^ n_command ^ n_subcode ^ n_data;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_address  = r_address;
    assign o_frame_reserved = 8'd0;
    assign o_frame_command  = r_command;
    assign o_frame_subcode  = r_subcode;
    assign o_frame_data     = r_data;
    assign o_frame_check    = r_check;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The input side is held off only by a full, stalled output register.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output register could take an item");

    // Every frame on the output carries a consistent check byte.
    a_check_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_check == (o_frame_address ^ o_frame_reserved ^
                         o_frame_command ^ o_frame_subcode ^ o_frame_data)))
        else $error("frame check byte does not match bytes 0 to 4");

    // A stop command never changes the remembered motion command.
    a_stop_keeps_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (op == ptzfe_pkg::OP_STOP)) |=> $stable(r_last_cmd))
        else $error("stop command changed the last motion command");

    // An accepted command always produces a frame in the next cycle.
    a_accept_gives_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted command produced no frame");

endmodule
`default_nettype wire
